@@ sv/iqso_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iqso_pkg - shared types and constants
// Widths, CORDIC angle table, register and mode codes of the IQ stereo
// output formatter.
// ----------------------------------------------------------------------------
package iqso_pkg;

    // CORDIC datapath: x/y carry 16 guard bits, z holds radians * 2^24
    localparam int XW            = 35;
    localparam int ZW            = 29;
    localparam int GUARD         = 16;
    localparam int ANG_TABLE_LEN = 24;
    localparam int XSPLIT        = 17;

    localparam logic signed [ZW-1:0] PI_Q24     = 29'sd52707179;
    localparam logic        [29:0]   INV_K_Q30  = 30'd652032874;
    localparam logic signed [13:0]   PHASE_GAIN = 14'sd5000;

    // configuration register indexes
    localparam logic REG_OUTPUT_MODE = 1'b0;
    localparam logic REG_NORM_GAIN   = 1'b1;

    // output modes
    localparam logic [1:0] MODE_REAL      = 2'd0;
    localparam logic [1:0] MODE_IQ        = 2'd1;
    localparam logic [1:0] MODE_QI        = 2'd2;
    localparam logic [1:0] MODE_ENV_PHASE = 2'd3;

    // per-beat control that travels with the data
    typedef struct packed {
        logic valid;
        logic zero;
    } ctl_t;

    // arctan(2^-i) in radians * 2^24, rounded
    function automatic logic [23:0] atan_q24(input logic [4:0] idx);
        logic [23:0] v;
        case (idx)
            5'd0:    v = 24'd13176795;
            5'd1:    v = 24'd7778716;
            5'd2:    v = 24'd4110060;
            5'd3:    v = 24'd2086331;
            5'd4:    v = 24'd1047214;
            5'd5:    v = 24'd524117;
            5'd6:    v = 24'd262123;
            5'd7:    v = 24'd131069;
            5'd8:    v = 24'd65536;
            5'd9:    v = 24'd32768;
            5'd10:   v = 24'd16384;
            5'd11:   v = 24'd8192;
            5'd12:   v = 24'd4096;
            5'd13:   v = 24'd2048;
            5'd14:   v = 24'd1024;
            5'd15:   v = 24'd512;
            5'd16:   v = 24'd256;
            5'd17:   v = 24'd128;
            5'd18:   v = 24'd64;
            5'd19:   v = 24'd32;
            5'd20:   v = 24'd16;
            5'd21:   v = 24'd8;
            5'd22:   v = 24'd4;
            5'd23:   v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ sv/iqso_cordic_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iqso_cordic_stage - one vectoring CORDIC micro-rotation
// Rotates (x, y) toward the positive x axis by atan(2^-STAGE), registered.
// ----------------------------------------------------------------------------
module iqso_cordic_stage #(
    parameter int STAGE = 0
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 en,
    input  iqso_pkg::ctl_t                      ctl_in,
    input  wire logic signed [iqso_pkg::XW-1:0] x_in,
    input  wire logic signed [iqso_pkg::XW-1:0] y_in,
    input  wire logic signed [iqso_pkg::ZW-1:0] z_in,
    output iqso_pkg::ctl_t                      ctl_out,
    output logic signed      [iqso_pkg::XW-1:0] x_out,
    output logic signed      [iqso_pkg::XW-1:0] y_out,
    output logic signed      [iqso_pkg::ZW-1:0] z_out
);

    localparam logic signed [iqso_pkg::ZW-1:0] ATAN =
        iqso_pkg::ZW'(iqso_pkg::atan_q24(5'(STAGE)));

    iqso_pkg::ctl_t                      ctl_reg;
    logic signed [iqso_pkg::XW-1:0]      x_reg, y_reg, x_next, y_next;
    logic signed [iqso_pkg::ZW-1:0]      z_reg, z_next;
    logic signed [iqso_pkg::XW-1:0]      dx, dy;

    always_comb begin
        dx = y_in >>> STAGE;
        dy = x_in >>> STAGE;
        if (y_in > 0) begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end else begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

endmodule
`default_nettype wire

@@ sv/iqso_cordic.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iqso_cordic - pipelined vectoring CORDIC
// Pre-rotation stage (half-plane fold) followed by NSTG micro-rotation stages.
// ----------------------------------------------------------------------------
module iqso_cordic #(
    parameter int NSTG = 16
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 en,
    input  wire                                 s_valid,
    input  wire logic signed [15:0]             re,
    input  wire logic signed [15:0]             im,
    output iqso_pkg::ctl_t                      ctl_out,
    output logic signed      [iqso_pkg::XW-1:0] x_out,
    output logic signed      [iqso_pkg::ZW-1:0] z_out
);

    localparam int XW = iqso_pkg::XW;
    localparam int ZW = iqso_pkg::ZW;

    iqso_pkg::ctl_t        ctl_w [0:NSTG];
    logic signed [XW-1:0]  x_w   [0:NSTG];
    logic signed [XW-1:0]  y_w   [0:NSTG];
    logic signed [ZW-1:0]  z_w   [0:NSTG];

    iqso_pkg::ctl_t        ctl0_reg, ctl0_next;
    logic signed [XW-1:0]  x0_reg, y0_reg, x0_next, y0_next, re_x, im_x;
    logic signed [ZW-1:0]  z0_reg, z0_next;

    // fold left half-plane onto the right one, seed the angle with +/-pi
    always_comb begin
        re_x = {{(XW-16){re[15]}}, re};
        im_x = {{(XW-16){im[15]}}, im};
        ctl0_next.valid = s_valid;
        ctl0_next.zero  = (re == 16'sd0) && (im == 16'sd0);
        if (re < 0) begin
            x0_next = (-re_x) <<< iqso_pkg::GUARD;
            y0_next = (-im_x) <<< iqso_pkg::GUARD;
            z0_next = (im >= 0) ? iqso_pkg::PI_Q24 : -iqso_pkg::PI_Q24;
        end else begin
            x0_next = re_x <<< iqso_pkg::GUARD;
            y0_next = im_x <<< iqso_pkg::GUARD;
            z0_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl0_reg <= '0;
        end else if (en) begin
            ctl0_reg <= ctl0_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg <= x0_next;
            y0_reg <= y0_next;
            z0_reg <= z0_next;
        end
    end

    assign ctl_w[0] = ctl0_reg;
    assign x_w[0]   = x0_reg;
    assign y_w[0]   = y0_reg;
    assign z_w[0]   = z0_reg;

    for (genvar g = 0; g < NSTG; g++) begin : g_stage
        iqso_cordic_stage #(
            .STAGE (g)
        ) u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_in  (ctl_w[g]),
            .x_in    (x_w[g]),
            .y_in    (y_w[g]),
            .z_in    (z_w[g]),
            .ctl_out (ctl_w[g+1]),
            .x_out   (x_w[g+1]),
            .y_out   (y_w[g+1]),
            .z_out   (z_w[g+1])
        );
    end

    assign ctl_out = ctl_w[NSTG];
    assign x_out   = x_w[NSTG];
    assign z_out   = z_w[NSTG];

endmodule
`default_nettype wire

@@ sv/iqso_post.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iqso_post - envelope and phase scaling
// Two stages: gain multiplies, then round to 16 bits, saturating the phase.
// ----------------------------------------------------------------------------
module iqso_post (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 en,
    input  iqso_pkg::ctl_t                      ctl_in,
    input  wire logic signed [iqso_pkg::XW-1:0] x_in,
    input  wire logic signed [iqso_pkg::ZW-1:0] z_in,
    output iqso_pkg::ctl_t                      ctl_out,
    output logic signed      [15:0]             env,
    output logic signed      [15:0]             phase
);

    localparam int XS = iqso_pkg::XSPLIT;
    localparam int PW = XS + 30;               // partial product width
    localparam int ZP = iqso_pkg::ZW + 14;     // phase product width

    iqso_pkg::ctl_t         ctl_a_reg, ctl_b_reg;
    logic [PW-1:0]          p_hi_reg, p_lo_reg, p_hi_next, p_lo_next;
    logic signed [ZP-1:0]   pz_reg, pz_next, pz_rnd;
    logic [PW+XS:0]         env_sum;
    logic signed [ZP-25:0]  ph_q;
    logic signed [15:0]     env_reg, phase_reg, env_next, phase_next;

    // x is never negative after the fold; split it so each multiply stays narrow
    always_comb begin
        p_hi_next = x_in[iqso_pkg::XW-2:XS] * iqso_pkg::INV_K_Q30;
        p_lo_next = x_in[XS-1:0] * iqso_pkg::INV_K_Q30;
        pz_next   = z_in * iqso_pkg::PHASE_GAIN;
    end

    always_comb begin
        env_sum = {1'b0, p_hi_reg, {XS{1'b0}}} + (PW+XS+1)'(p_lo_reg)
                + ((PW+XS+1)'(1) << 51);
        pz_rnd  = pz_reg + (ZP'(1) <<< 23);
        ph_q    = pz_rnd[ZP-1:24];
        if (ctl_a_reg.zero) begin
            env_next   = '0;
            phase_next = '0;
        end else begin
            // envelope stays far below 2^15 for any 16-bit input
            env_next = 16'({1'b0, env_sum[PW+XS:52]});
            if (ph_q > (ZP-24)'(32767)) begin
                phase_next = 16'sd32767;
            end else if (ph_q < -(ZP-24)'(32768)) begin
                phase_next = -16'sd32768;
            end else begin
                phase_next = ph_q[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end else if (en) begin
            ctl_a_reg <= ctl_in;
            ctl_b_reg <= ctl_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_hi_reg  <= p_hi_next;
            p_lo_reg  <= p_lo_next;
            pz_reg    <= pz_next;
            env_reg   <= env_next;
            phase_reg <= phase_next;
        end
    end

    assign ctl_out = ctl_b_reg;
    assign env     = env_reg;
    assign phase   = phase_reg;

endmodule
`default_nettype wire

@@ sv/iqso_scale.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iqso_scale - I/Q normalization gain
// Multiply and round, then delay to line up with the CORDIC path.
// ----------------------------------------------------------------------------
module iqso_scale #(
    parameter int DLY = 17
) (
    input  wire                     aclk,
    input  wire                     en,
    input  wire logic signed [15:0] re,
    input  wire logic signed [15:0] im,
    input  wire logic        [15:0] gain,
    output logic signed      [15:0] re_out,
    output logic signed      [15:0] im_out
);

    logic signed [32:0] prod_re_reg, prod_im_reg, prod_re_next, prod_im_next;
    logic signed [32:0] rnd_re, rnd_im;
    logic signed [15:0] sc_re_reg, sc_im_reg, sc_re_next, sc_im_next;
    logic        [31:0] dly_reg [0:DLY-1];

    always_comb begin
        prod_re_next = re * $signed({1'b0, gain});
        prod_im_next = im * $signed({1'b0, gain});
        rnd_re       = prod_re_reg + (33'sd1 <<< 17);
        rnd_im       = prod_im_reg + (33'sd1 <<< 17);
        // 33-bit product shifted by 18 always fits 16 bits
        sc_re_next   = {rnd_re[32], rnd_re[32:18]};
        sc_im_next   = {rnd_im[32], rnd_im[32:18]};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_re_reg <= prod_re_next;
            prod_im_reg <= prod_im_next;
            sc_re_reg   <= sc_re_next;
            sc_im_reg   <= sc_im_next;
            dly_reg[0]  <= {sc_im_reg, sc_re_reg};
            for (int i = 1; i < DLY; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign re_out = dly_reg[DLY-1][15:0];
    assign im_out = dly_reg[DLY-1][31:16];

endmodule
`default_nettype wire

@@ sv/iq_stereo_output_formatter_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iq_stereo_output_formatter_top - complex sample to stereo PCM pair
// Each input beat (I, Q in Q2.14) yields one output beat (left, right).
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one complex sample per beat; m_ channel returns one
//   stereo pair per beat, in order. Throughput is one beat per clock while the
//   receiver takes every beat. From input acceptance to m_tvalid a beat passes
//   the fold stage, one register per CORDIC iteration, two post-scaling stages
//   and the output register. CORDIC_STAGES defaults to 16 iterations; values
//   above 24 are clamped to 24 iterations.
//   Candidates: I and Q times norm_gain / 2^18, envelope (|z| * 256) and phase
//   (atan2 * 5000), all rounded to signed 16 bits, the phase also saturated.
//   output_mode picks real/real, I/Q, Q/I or envelope/phase.
//   Configuration is written through cfg_wr_en/cfg_addr/cfg_wdata, by the user only
//   while the block is idle (the block itself does not enforce this); a write takes effect at the next clock edge.
//   Reset (aresetn low, synchronous) empties the pipeline and restores
//   output_mode = 0 and norm_gain = 48000.
//   When the receiver stalls, one more beat is held in a skid register
//   behind the output register; then s_tready drops and the whole pipeline
//   freezes with no beat lost or repeated.
// ----------------------------------------------------------------------------
module iq_stereo_output_formatter_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    // input beat
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,     // [15:0] in_real, [31:16] in_imag
    // result beat
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,     // [15:0] left_sample, [31:16] right_sample
    // configuration writes
    input  wire         cfg_wr_en,
    input  wire         cfg_addr,
    input  wire  [15:0] cfg_wdata
);

    localparam int NSTG = (CORDIC_STAGES > iqso_pkg::ANG_TABLE_LEN) ?
                          iqso_pkg::ANG_TABLE_LEN : CORDIC_STAGES;

    logic [1:0]          mode_reg;
    logic [15:0]         gain_reg;

    logic                en;
    logic signed [15:0]  in_real, in_imag;

    iqso_pkg::ctl_t                      cor_ctl, post_ctl;
    logic signed [iqso_pkg::XW-1:0]      cor_x;
    logic signed [iqso_pkg::ZW-1:0]      cor_z;
    logic signed [15:0]                  env, phase, sc_re, sc_im;
    logic signed [15:0]                  left_next, right_next;
    logic                                pipe_push;

    logic                out_valid_reg, skid_valid_reg;
    logic [31:0]         out_data_reg, skid_data_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= iqso_pkg::MODE_REAL;
            gain_reg <= 16'd48000;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                iqso_pkg::REG_OUTPUT_MODE: mode_reg <= cfg_wdata[1:0];
                iqso_pkg::REG_NORM_GAIN:   gain_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline ----------------
    // Whole pipeline advances unless the skid register is occupied.
    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign in_real  = s_tdata[15:0];
    assign in_imag  = s_tdata[31:16];

    iqso_cordic #(
        .NSTG (NSTG)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .s_valid (s_tvalid),
        .re      (in_real),
        .im      (in_imag),
        .ctl_out (cor_ctl),
        .x_out   (cor_x),
        .z_out   (cor_z)
    );

    iqso_post u_post (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_in  (cor_ctl),
        .x_in    (cor_x),
        .z_in    (cor_z),
        .ctl_out (post_ctl),
        .env     (env),
        .phase   (phase)
    );

    // two multiply/round stages plus delay = fold + CORDIC + post depth
    iqso_scale #(
        .DLY (NSTG + 1)
    ) u_scale (
        .aclk   (aclk),
        .en     (en),
        .re     (in_real),
        .im     (in_imag),
        .gain   (gain_reg),
        .re_out (sc_re),
        .im_out (sc_im)
    );

    // ---------------- channel mapping ----------------
    always_comb begin
        unique case (mode_reg)
            iqso_pkg::MODE_IQ: begin
                left_next  = sc_re;
                right_next = sc_im;
            end
            iqso_pkg::MODE_QI: begin
                left_next  = sc_im;
                right_next = sc_re;
            end
            iqso_pkg::MODE_ENV_PHASE: begin
                left_next  = env;
                right_next = phase;
            end
            default: begin
                left_next  = sc_re;
                right_next = sc_re;
            end
        endcase
    end

    // A beat leaves the last pipeline stage on an enabled cycle when that stage holds a valid beat.
    assign pipe_push = en && post_ctl.valid;

    // ---------------- output register and skid ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                // drain the held beat first
                out_valid_reg  <= 1'b1;
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= pipe_push;
                if (pipe_push) begin
                    out_data_reg <= {right_next, left_next};
                end
            end
        end else if (pipe_push) begin
            // receiver stalled: park the arriving beat
            skid_valid_reg <= 1'b1;
            skid_data_reg  <= {right_next, left_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // skid holds a beat only behind a full output register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // a beat leaving the pipeline always lands in output or skid
    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_push |=> out_valid_reg)
        else $error("pipeline beat dropped at output");

    // accepted input shows up as valid in the fold stage
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> u_cordic.ctl0_reg.valid)
        else $error("accepted beat missing in first stage");

    // frozen pipeline keeps its last stage
    a_freeze_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(post_ctl) && $stable(env) && $stable(phase))
        else $error("pipeline moved while stalled");
`endif

endmodule
`default_nettype wire
